### src/brsp_pkg.sv
package brsp_pkg;

  // Parser phases. A message starts in PH_START; PH_DONE means the message
  // is complete but end of buffer has not been seen yet.
  typedef enum logic [2:0] {
    PH_START,
    PH_COUNT,
    PH_ONE,
    PH_WORD,
    PH_SLEN,
    PH_SBYTES,
    PH_DONE,
    PH_SKIP
  } phase_e;

  typedef enum logic [2:0] {
    KIND_INT,
    KIND_UINT,
    KIND_FLOAT,
    KIND_BOOL,
    KIND_STR_LEN,
    KIND_STR_BYTE,
    KIND_NULL,
    KIND_ERROR
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_SHORT_READ,
    ERR_TRAILING
  } err_e;

  // Field type codes as stored in field_types.
  localparam logic [3:0] TYPE_FLOAT   = 4'd2;
  localparam logic [3:0] TYPE_BOOL    = 4'd3;
  localparam logic [3:0] TYPE_STR     = 4'd4;
  localparam logic [3:0] TYPE_OPT_OFS = 4'd5;

  // Configuration register indexes (byte address = 8 * index).
  localparam logic [1:0] REG_FIELD_COUNT = 2'd0;
  localparam logic [1:0] REG_FIELD_TYPES = 2'd1;
  localparam logic [1:0] REG_LIST_MODE   = 2'd2;

  // Result queue.
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  field_number;
    logic [31:0] record_number;
    logic [63:0] value;
    err_e        error_code;
    logic        record_end;
    logic        message_end;
  } result_t;

  // Phase in which the first byte of a field of type t is read.
  function automatic phase_e first_phase(logic [3:0] t);
    phase_e ph;
    if (t <= TYPE_FLOAT) begin
      ph = PH_WORD;
    end else if (t == TYPE_STR) begin
      ph = PH_SLEN;
    end else begin
      ph = PH_ONE;
    end
    return ph;
  endfunction

endpackage

### src/brsp_in_if.sv
interface brsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

### src/brsp_out_if.sv
interface brsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  field_number;
  logic [31:0] record_number;
  logic [63:0] value;
  logic [1:0]  error_code;
  logic        record_end;
  logic        message_end;

  modport source (
    output valid, output kind, output field_number, output record_number,
    output value, output error_code, output record_end, output message_end,
    input ready
  );
  modport sink (
    input valid, input kind, input field_number, input record_number,
    input value, input error_code, input record_end, input message_end,
    output ready
  );
endinterface

### src/binary_record_stream_parser.sv
// Channel   Direction  Word
// in_i      sink       one message byte plus end_of_buffer flag
// out_o     source     one decoded result (kind, field, record, value, flags)
// APB       slave      field_count @0x00, field_types @0x08, list_mode @0x10
//
// Each accepted byte is decoded by one pass of logic at the edge that accepts it;
// its one or two results land in a four-word result queue, from which out_o takes them in order.
// Sustained rate is one byte per cycle. in_i.ready is high while the queue has
// room for two words, so a stalled out_o, or a run of bytes that each yield a
// decoded value plus a short-read error, holds off input.
// Asynchronous active-low reset clears parser, queue and config (field_count to 1).
module binary_record_stream_parser #(
  parameter int MAX_FIELDS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  brsp_in_if.sink           in_i,
  brsp_out_if.source        out_o
);

  localparam logic [4:0] MaxFieldsW = 5'(MAX_FIELDS);

  // Configuration registers.
  logic [4:0]  field_count_q;
  logic [63:0] field_types_q;
  logic        list_mode_q;

  logic [1:0] reg_index;
  logic       cfg_write;

  assign reg_index = paddr[4:3];
  assign cfg_write = psel & penable & pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_count_q <= 5'd1;
      field_types_q <= '0;
      list_mode_q   <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_index)
        brsp_pkg::REG_FIELD_COUNT: field_count_q <= pwdata[4:0];
        brsp_pkg::REG_FIELD_TYPES: field_types_q <= pwdata;
        brsp_pkg::REG_LIST_MODE:   list_mode_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      brsp_pkg::REG_FIELD_COUNT: prdata = {59'd0, field_count_q};
      brsp_pkg::REG_FIELD_TYPES: prdata = field_types_q;
      brsp_pkg::REG_LIST_MODE:   prdata = {63'd0, list_mode_q};
      default:                   prdata = '0;
    endcase
  end

  // A field count of zero behaves as one; counts above MAX_FIELDS are clamped.
  logic [4:0] eff_count;
  always_comb begin
    if (field_count_q == 5'd0) begin
      eff_count = 5'd1;
    end else if (field_count_q > MaxFieldsW) begin
      eff_count = MaxFieldsW;
    end else begin
      eff_count = field_count_q;
    end
  end

  // Parser state.
  brsp_pkg::phase_e phase_q, phase_d;
  logic [3:0]  fi_q, fi_d;
  logic [2:0]  bc_q, bc_d;
  logic [63:0] asm_q, asm_d;
  logic [31:0] rc_q, rc_d;
  logic [31:0] rt_q, rt_d;
  logic [31:0] sr_q, sr_d;
  logic        ts_q, ts_d;

  // Result queue.
  brsp_pkg::result_t fifo_q [brsp_pkg::RES_DEPTH];
  logic [brsp_pkg::RES_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [brsp_pkg::RES_PTR_W:0]   count_q;

  logic in_fire, out_fire;
  brsp_pkg::result_t res [2];
  logic [1:0]  n_push;
  logic        do_close, do_begin;
  logic [3:0]  cur_type, base;
  logic [31:0] len;

  assign in_i.ready = (count_q <= (brsp_pkg::RES_PTR_W + 1)'(brsp_pkg::RES_DEPTH - 2));
  assign in_fire    = in_i.valid & in_i.ready;
  assign out_fire   = out_o.valid & out_o.ready;

  function automatic brsp_pkg::result_t make_result(brsp_pkg::kind_e k, logic [3:0] fn,
                                                    logic [31:0] rn, logic [63:0] v,
                                                    brsp_pkg::err_e e);
    brsp_pkg::result_t r;
    r.kind          = k;
    r.field_number  = fn;
    r.record_number = rn;
    r.value         = v;
    r.error_code    = e;
    r.record_end    = 1'b0;
    r.message_end   = 1'b0;
    return r;
  endfunction

  // One decoding pass per accepted byte. The steps run in the order of the
  // message grammar: message start, byte decode, field close (which may
  // start the next field or finish the message), then the end-of-buffer check.
  always_comb begin
    phase_d  = phase_q;
    fi_d     = fi_q;
    bc_d     = bc_q;
    asm_d    = asm_q;
    rc_d     = rc_q;
    rt_d     = rt_q;
    sr_d     = sr_q;
    ts_d     = ts_q;
    res[0]   = '0;
    res[1]   = '0;
    n_push   = 2'd0;
    do_close = 1'b0;
    do_begin = 1'b0;
    cur_type = 4'd0;
    base     = 4'd0;
    len      = 32'd0;

    if (in_fire) begin
      if (phase_d == brsp_pkg::PH_START) begin
        fi_d = '0;
        rc_d = '0;
        sr_d = '0;
        if (list_mode_q) begin
          phase_d = brsp_pkg::PH_COUNT;
          bc_d    = '0;
          asm_d   = '0;
          ts_d    = 1'b0;
        end else begin
          rt_d    = 32'd1;
          ts_d    = 1'b0;
          bc_d    = '0;
          asm_d   = '0;
          phase_d = brsp_pkg::first_phase(field_types_q[{fi_d, 2'b00} +: 4]);
        end
      end

      cur_type = field_types_q[{fi_d, 2'b00} +: 4];

      unique case (phase_d)
        brsp_pkg::PH_COUNT: begin
          asm_d = {in_i.data_byte, asm_d[63:8]};
          bc_d  = bc_d + 3'd1;
          if (bc_d == 3'd4) begin
            rt_d = asm_d[63:32];
            if (rt_d == 32'd0) begin
              // Empty list: the message is complete without any result.
              phase_d = in_i.end_of_buffer ? brsp_pkg::PH_START : brsp_pkg::PH_DONE;
            end else begin
              do_begin = 1'b1;
            end
          end
        end
        brsp_pkg::PH_ONE: begin
          if (cur_type >= brsp_pkg::TYPE_OPT_OFS && !ts_d) begin
            base = cur_type - brsp_pkg::TYPE_OPT_OFS;
            if (in_i.data_byte == 8'd0 || base > brsp_pkg::TYPE_STR) begin
              // Null tag, or an unknown optional type that always reads as null.
              res[0] = make_result(brsp_pkg::KIND_NULL, fi_d, rc_d, 64'd0, brsp_pkg::ERR_NONE);
              n_push   = 2'd1;
              do_close = 1'b1;
            end else begin
              ts_d    = 1'b1;
              bc_d    = '0;
              asm_d   = '0;
              phase_d = brsp_pkg::first_phase(base);
            end
          end else begin
            res[0] = make_result(brsp_pkg::KIND_BOOL, fi_d, rc_d,
                                 {63'd0, in_i.data_byte != 8'd0}, brsp_pkg::ERR_NONE);
            n_push   = 2'd1;
            do_close = 1'b1;
          end
        end
        brsp_pkg::PH_WORD: begin
          asm_d = {in_i.data_byte, asm_d[63:8]};
          bc_d  = bc_d + 3'd1;
          if (bc_d == 3'd0) begin
            base = (cur_type >= brsp_pkg::TYPE_OPT_OFS) ?
                   cur_type - brsp_pkg::TYPE_OPT_OFS : cur_type;
            res[0] = make_result((base <= brsp_pkg::TYPE_FLOAT) ?
                                 brsp_pkg::kind_e'(base[2:0]) : brsp_pkg::KIND_INT,
                                 fi_d, rc_d, asm_d, brsp_pkg::ERR_NONE);
            n_push   = 2'd1;
            do_close = 1'b1;
          end
        end
        brsp_pkg::PH_SLEN: begin
          asm_d = {in_i.data_byte, asm_d[63:8]};
          bc_d  = bc_d + 3'd1;
          if (bc_d == 3'd4) begin
            len    = asm_d[63:32];
            res[0] = make_result(brsp_pkg::KIND_STR_LEN, fi_d, rc_d, {32'd0, len},
                                 brsp_pkg::ERR_NONE);
            n_push = 2'd1;
            if (len == 32'd0) begin
              do_close = 1'b1;
            end else begin
              sr_d    = len;
              phase_d = brsp_pkg::PH_SBYTES;
            end
          end
        end
        brsp_pkg::PH_SBYTES: begin
          res[0] = make_result(brsp_pkg::KIND_STR_BYTE, fi_d, rc_d, {56'd0, in_i.data_byte},
                               brsp_pkg::ERR_NONE);
          n_push = 2'd1;
          sr_d   = sr_d - 32'd1;
          if (sr_d == 32'd0) begin
            do_close = 1'b1;
          end
        end
        brsp_pkg::PH_DONE: begin
          // A byte after a complete message: report trailing data once.
          fi_d   = '0;
          res[0] = make_result(brsp_pkg::KIND_ERROR, fi_d, rc_d, 64'd0,
                               brsp_pkg::ERR_TRAILING);
          res[0].message_end = 1'b1;
          n_push  = 2'd1;
          phase_d = brsp_pkg::PH_SKIP;
        end
        brsp_pkg::PH_START, brsp_pkg::PH_SKIP: ;
      endcase

      if (do_close) begin
        if (({1'b0, fi_d} + 5'd1) >= eff_count) begin
          res[0].record_end = 1'b1;
          rc_d = rc_d + 32'd1;
          fi_d = '0;
          if (rc_d == rt_d) begin
            if (in_i.end_of_buffer) begin
              res[0].message_end = 1'b1;
              phase_d = brsp_pkg::PH_START;
            end else begin
              phase_d = brsp_pkg::PH_DONE;
            end
          end else begin
            do_begin = 1'b1;
          end
        end else begin
          fi_d     = fi_d + 4'd1;
          do_begin = 1'b1;
        end
      end

      if (do_begin) begin
        ts_d    = 1'b0;
        bc_d    = '0;
        asm_d   = '0;
        phase_d = brsp_pkg::first_phase(field_types_q[{fi_d, 2'b00} +: 4]);
      end

      // End of buffer inside an incomplete message is a short read.
      if (in_i.end_of_buffer && phase_d != brsp_pkg::PH_START) begin
        if (phase_d != brsp_pkg::PH_SKIP) begin
          res[n_push[0]] = make_result(brsp_pkg::KIND_ERROR, fi_d, rc_d, 64'd0,
                                       brsp_pkg::ERR_SHORT_READ);
          res[n_push[0]].message_end = 1'b1;
          n_push = n_push + 2'd1;
        end
        phase_d = brsp_pkg::PH_START;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= brsp_pkg::PH_START;
      fi_q    <= '0;
      bc_q    <= '0;
      asm_q   <= '0;
      rc_q    <= '0;
      rt_q    <= '0;
      sr_q    <= '0;
      ts_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fi_q    <= fi_d;
      bc_q    <= bc_d;
      asm_q   <= asm_d;
      rc_q    <= rc_d;
      rt_q    <= rt_d;
      sr_q    <= sr_d;
      ts_q    <= ts_d;
    end
  end

  // Result queue: up to two words written and one word read per cycle.
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_ptr_q] <= res[0];
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_ptr_q + brsp_pkg::RES_PTR_W'(1)] <= res[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + brsp_pkg::RES_PTR_W'(n_push);
      rd_ptr_q <= rd_ptr_q + brsp_pkg::RES_PTR_W'(out_fire);
      count_q  <= count_q + (brsp_pkg::RES_PTR_W + 1)'(n_push)
                          - (brsp_pkg::RES_PTR_W + 1)'(out_fire);
    end
  end

  brsp_pkg::result_t head;
  assign head = fifo_q[rd_ptr_q];

  assign out_o.valid         = (count_q != '0);
  assign out_o.kind          = head.kind;
  assign out_o.field_number  = head.field_number;
  assign out_o.record_number = head.record_number;
  assign out_o.value         = head.value;
  assign out_o.error_code    = head.error_code;
  assign out_o.record_end    = head.record_end;
  assign out_o.message_end   = head.message_end;

  // The queue never overflows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (brsp_pkg::RES_PTR_W + 1)'(brsp_pkg::RES_DEPTH))
    else $error("result queue overflow");

  // An end-of-buffer byte always leaves the parser at the start of a message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.end_of_buffer |=> phase_q == brsp_pkg::PH_START)
    else $error("parser not back at message start after end of buffer");

  // Bytes skipped after trailing data produce nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q == brsp_pkg::PH_SKIP |-> n_push == 2'd0)
    else $error("result produced while skipping trailing data");

  // A second result in one step is always the short-read error closing the message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_push == 2'd2 |-> res[1].kind == brsp_pkg::KIND_ERROR &&
                       res[1].error_code == brsp_pkg::ERR_SHORT_READ &&
                       res[1].message_end && !res[1].record_end)
    else $error("unexpected second result");

  // Error words never carry a record end or a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_push != 2'd0 && res[0].kind == brsp_pkg::KIND_ERROR |->
      !res[0].record_end && res[0].value == 64'd0 && res[0].message_end)
    else $error("malformed error result");

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_FIELDS = 16;
  localparam int ITEM_TARGET = 1350;
  // The last input words go in with no random input gaps and out_ch.ready held high.
  localparam int CALM_ITEMS = 150;
  // One decode pass per accepted word, so the settle time covers any tail.
  localparam int SETTLE_CYCLES = 8;
  // Cycles with no word moving on either channel before the run is abandoned.
  localparam int IDLE_LIMIT = 4000;

  // Decoder of record messages that runs alongside the block. It keeps its own
  // copy of the configuration and of the parse state. Every accepted input
  // word is decoded here, and the results it gives, up to two, are queued.
  class record_decoder;
    logic [4:0]  cfg_count;
    logic [63:0] cfg_types;
    logic        cfg_list;

    brsp_pkg::phase_e  ph;
    logic [3:0]  fidx;
    logic [2:0]  bcnt;
    logic [63:0] shreg;
    logic [31:0] rec_cnt;
    logic [31:0] rec_tot;
    logic [31:0] str_left;
    logic        tag_seen;

    brsp_pkg::result_t step_res[2];
    int                n_step;
    brsp_pkg::result_t due_results[$];
    int                mismatches;

    function new();
      cfg_count = 5'd1;
      cfg_types = '0;
      cfg_list = 1'b0;
      ph = brsp_pkg::PH_START;
      fidx = '0;
      bcnt = '0;
      shreg = '0;
      rec_cnt = '0;
      rec_tot = '0;
      str_left = '0;
      tag_seen = 1'b0;
      n_step = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        brsp_pkg::REG_FIELD_COUNT: cfg_count = val[4:0];
        brsp_pkg::REG_FIELD_TYPES: cfg_types = val;
        brsp_pkg::REG_LIST_MODE:   cfg_list = val[0];
        default: ;
      endcase
    endfunction

    function int fields_per_record();
      int fc;
      fc = int'(cfg_count);
      if (fc == 0) fc = 1;
      if (fc > MAX_FIELDS) fc = MAX_FIELDS;
      return fc;
    endfunction

    function logic [3:0] type_now();
      return cfg_types[4*fidx +: 4];
    endfunction

    function int emit(brsp_pkg::kind_e k, logic [63:0] v, brsp_pkg::err_e e);
      int i;
      i = (n_step > 1) ? 1 : n_step;
      step_res[i].kind = k;
      step_res[i].field_number = fidx;
      step_res[i].record_number = rec_cnt;
      step_res[i].value = v;
      step_res[i].error_code = e;
      step_res[i].record_end = 1'b0;
      step_res[i].message_end = 1'b0;
      n_step = i + 1;
      return i;
    endfunction

    function void start_base(int b);
      bcnt = '0;
      shreg = '0;
      if (b <= int'(brsp_pkg::TYPE_FLOAT)) begin
        ph = brsp_pkg::PH_WORD;
      end else if (b == int'(brsp_pkg::TYPE_BOOL)) begin
        ph = brsp_pkg::PH_ONE;
      end else begin
        ph = brsp_pkg::PH_SLEN;
      end
    endfunction

    function void begin_field();
      int t;
      t = int'(type_now());
      tag_seen = 1'b0;
      bcnt = '0;
      shreg = '0;
      if (t >= int'(brsp_pkg::TYPE_OPT_OFS)) begin
        ph = brsp_pkg::PH_ONE;
      end else begin
        start_base(t);
      end
    endfunction

    function void complete_message(int i, logic eob);
      if (eob) begin
        if (i >= 0) step_res[i].message_end = 1'b1;
        ph = brsp_pkg::PH_START;
      end else begin
        ph = brsp_pkg::PH_DONE;
      end
    endfunction

    function void close_field(int i, logic eob);
      if (int'(fidx) + 1 >= fields_per_record()) begin
        step_res[i].record_end = 1'b1;
        rec_cnt++;
        fidx = '0;
        if (rec_cnt == rec_tot) begin
          complete_message(i, eob);
          return;
        end
      end else begin
        fidx++;
      end
      begin_field();
    endfunction

    // Returns 1 when the word is dropped while skipping to end of buffer.
    function logic decode_byte(logic [7:0] data, logic eob);
      int t;
      int b;
      int i;
      logic [31:0] len;
      logic ignored;
      ignored = (ph == brsp_pkg::PH_SKIP);
      n_step = 0;
      if (ph == brsp_pkg::PH_START) begin
        fidx = '0;
        rec_cnt = '0;
        str_left = '0;
        if (cfg_list) begin
          ph = brsp_pkg::PH_COUNT;
          bcnt = '0;
          shreg = '0;
          tag_seen = 1'b0;
        end else begin
          rec_tot = 32'd1;
          begin_field();
        end
      end
      case (ph)
        brsp_pkg::PH_COUNT: begin
          shreg = {data, shreg[63:8]};
          bcnt++;
          if (bcnt == 3'd4) begin
            rec_tot = shreg[63:32];
            if (rec_tot == '0) begin
              complete_message(-1, eob);
            end else begin
              begin_field();
            end
          end
        end
        brsp_pkg::PH_ONE: begin
          t = int'(type_now());
          if (t >= int'(brsp_pkg::TYPE_OPT_OFS) && !tag_seen) begin
            if (data == 8'h00) begin
              i = emit(brsp_pkg::KIND_NULL, '0, brsp_pkg::ERR_NONE);
              close_field(i, eob);
            end else begin
              tag_seen = 1'b1;
              b = t - int'(brsp_pkg::TYPE_OPT_OFS);
              if (b > int'(brsp_pkg::TYPE_STR)) begin
                i = emit(brsp_pkg::KIND_NULL, '0, brsp_pkg::ERR_NONE);
                close_field(i, eob);
              end else begin
                start_base(b);
              end
            end
          end else begin
            i = emit(brsp_pkg::KIND_BOOL, (data != 8'h00) ? 64'd1 : 64'd0,
                     brsp_pkg::ERR_NONE);
            close_field(i, eob);
          end
        end
        brsp_pkg::PH_WORD: begin
          shreg = {data, shreg[63:8]};
          bcnt++;
          if (bcnt == 3'd0) begin
            t = int'(type_now());
            b = (t >= int'(brsp_pkg::TYPE_OPT_OFS)) ? t - int'(brsp_pkg::TYPE_OPT_OFS) : t;
            i = emit((b <= int'(brsp_pkg::TYPE_FLOAT)) ? brsp_pkg::kind_e'(b)
                                                       : brsp_pkg::KIND_INT,
                     shreg, brsp_pkg::ERR_NONE);
            close_field(i, eob);
          end
        end
        brsp_pkg::PH_SLEN: begin
          shreg = {data, shreg[63:8]};
          bcnt++;
          if (bcnt == 3'd4) begin
            len = shreg[63:32];
            i = emit(brsp_pkg::KIND_STR_LEN, {32'd0, len}, brsp_pkg::ERR_NONE);
            if (len == '0) begin
              close_field(i, eob);
            end else begin
              str_left = len;
              ph = brsp_pkg::PH_SBYTES;
            end
          end
        end
        brsp_pkg::PH_SBYTES: begin
          i = emit(brsp_pkg::KIND_STR_BYTE, {56'd0, data}, brsp_pkg::ERR_NONE);
          str_left--;
          if (str_left == '0) close_field(i, eob);
        end
        brsp_pkg::PH_DONE: begin
          fidx = '0;
          i = emit(brsp_pkg::KIND_ERROR, '0, brsp_pkg::ERR_TRAILING);
          step_res[i].message_end = 1'b1;
          ph = brsp_pkg::PH_SKIP;
        end
        default: ;
      endcase
      if (eob && ph != brsp_pkg::PH_START) begin
        if (ph != brsp_pkg::PH_SKIP) begin
          i = emit(brsp_pkg::KIND_ERROR, '0, brsp_pkg::ERR_SHORT_READ);
          step_res[i].message_end = 1'b1;
        end
        ph = brsp_pkg::PH_START;
      end
      for (int k = 0; k < n_step; k++) due_results.insert(due_results.size(), step_res[k]);
      return ignored;
    endfunction

    function void match_result(brsp_pkg::result_t got);
      brsp_pkg::result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: kind=%0d field=%0d record=%0d value=%h err=%0d",
                   got.kind, got.field_number, got.record_number, got.value,
                   got.error_code);
        end
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.field_number !== want.field_number ||
          got.record_number !== want.record_number || got.value !== want.value ||
          got.error_code !== want.error_code || got.record_end !== want.record_end ||
          got.message_end !== want.message_end) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result differs: expected kind=%0d field=%0d record=%0d value=%h",
                   want.kind, want.field_number, want.record_number, want.value);
          $display("  err=%0d rec_end=%b msg_end=%b; actual kind=%0d field=%0d record=%0d",
                   want.error_code, want.record_end, want.message_end,
                   got.kind, got.field_number, got.record_number);
          $display("  value=%h err=%0d rec_end=%b msg_end=%b",
                   got.value, got.error_code, got.record_end, got.message_end);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  brsp_in_if  in_ch();
  brsp_out_if out_ch();

  binary_record_stream_parser #(.MAX_FIELDS(MAX_FIELDS)) uut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  record_decoder decoder = new();

  int         items_sent;
  logic       calm;
  logic       gaps_on;
  logic [7:0] msg[$];

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Result side: ready drops for bursts of random length between runs of
  // ready cycles, except in the calm tail of the run.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(0, 40)) @(posedge clk_i);
    end
  end

  // Every result word that the block hands over is checked against the
  // oldest expectation.
  always @(posedge clk_i) begin : watch_results
    brsp_pkg::result_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.kind = brsp_pkg::kind_e'(out_ch.kind);
      got.field_number = out_ch.field_number;
      got.record_number = out_ch.record_number;
      got.value = out_ch.value;
      got.error_code = brsp_pkg::err_e'(out_ch.error_code);
      got.record_end = out_ch.record_end;
      got.message_end = out_ch.message_end;
      decoder.match_result(got);
    end
  end

  // Any stretch this long without a word moving means the block has hung.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  // Offers one input word, with an optional gap first, and returns at the
  // edge where it is taken.
  task automatic send_byte(logic [7:0] data, logic eob);
    if (gaps_on && !calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= data;
    in_ch.end_of_buffer <= eob;
    do @(posedge clk_i); while (!in_ch.ready);
    if (!decoder.decode_byte(data, eob)) items_sent++;
  endtask

  // Stops sending until every expected result has come out, then lets the
  // block settle so that it is idle for a register write.
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    while (decoder.due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    decoder.set_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(logic [4:0] count, logic [63:0] types, logic list);
    write_reg(brsp_pkg::REG_FIELD_COUNT, {59'd0, count});
    write_reg(brsp_pkg::REG_FIELD_TYPES, types);
    write_reg(brsp_pkg::REG_LIST_MODE, {63'd0, list});
  endtask

  function automatic logic [7:0] rand_octet();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [63:0] random_types();
    logic [63:0] r;
    int nib;
    for (int k = 0; k < 16; k++) begin
      nib = $urandom_range(0, 15);
      // Unknown codes are kept rarer than the real ones.
      if (nib > 9 && $urandom_range(0, 3) != 0) nib = $urandom_range(0, 9);
      r[4*k +: 4] = 4'(nib);
    end
    return r;
  endfunction

  // Appends one byte to the message under build.
  function automatic void add_octet(logic [7:0] v);
    msg.insert(msg.size(), v);
  endfunction

  function automatic void push_le(logic [31:0] v, int n);
    for (int k = 0; k < n; k++) add_octet(v[8*k +: 8]);
  endfunction

  // Appends the encoding of one field of type t to the message under build.
  function automatic void push_field(logic [3:0] t);
    int b;
    int len;
    logic [7:0] tag;
    b = int'(t);
    if (t >= brsp_pkg::TYPE_OPT_OFS) begin
      if ($urandom_range(0, 3) == 0) begin
        tag = 8'h00;
      end else begin
        tag = 8'($urandom_range(1, 255));
      end
      add_octet(tag);
      if (tag == 8'h00 || t >= 4'd10) return;
      b = b - int'(brsp_pkg::TYPE_OPT_OFS);
    end
    if (b <= int'(brsp_pkg::TYPE_FLOAT)) begin
      case ($urandom_range(0, 7))
        0: repeat (8) add_octet(8'h00);
        1: repeat (8) add_octet(8'hFF);
        2: begin
          // Most negative int, sign bit alone in the top byte.
          repeat (7) add_octet(8'h00);
          add_octet(8'h80);
        end
        default: repeat (8) add_octet(rand_octet());
      endcase
    end else if (b == int'(brsp_pkg::TYPE_BOOL)) begin
      add_octet(rand_octet());
    end else if ($urandom_range(0, 39) == 0) begin
      // A length far past the end: the rest of the message is string data.
      push_le($urandom, 4);
    end else begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
      push_le(len, 4);
      repeat (len) add_octet(rand_octet());
    end
  endfunction

  function automatic void build_message();
    int nrec;
    int nf;
    msg.delete();
    nf = decoder.fields_per_record();
    if (decoder.cfg_list) begin
      nrec = $urandom_range(0, (nf > 4) ? 2 : 4);
      if ($urandom_range(0, 9) == 0) begin
        push_le($urandom, 4);
      end else begin
        push_le(nrec, 4);
      end
    end else begin
      nrec = 1;
    end
    for (int r = 0; r < nrec; r++) begin
      for (int f = 0; f < nf; f++) push_field(decoder.cfg_types[4*f +: 4]);
    end
  endfunction

  // Sends one message, well formed in most cases, else cut short or
  // followed by trailing data.
  task automatic send_message();
    int pick;
    int cut;
    int extra;
    logic trailing;
    build_message();
    gaps_on = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 19);
    cut = msg.size();
    if (pick < 3 && msg.size() > 1) cut = $urandom_range(1, msg.size() - 1);
    trailing = (pick >= 3 && pick < 6);
    for (int k = 0; k < cut; k++) send_byte(msg[k], (k == cut - 1) && !trailing);
    if (trailing) begin
      extra = $urandom_range(1, 3);
      for (int k = 0; k < extra; k++) send_byte(rand_octet(), k == extra - 1);
    end
  endtask

  // Random words with end of buffer scattered in; the last one always closes
  // the buffer so that the next message starts clean.
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int k = 0; k < n; k++) begin
      send_byte(rand_octet(), (k == n - 1) || ($urandom_range(0, 3) == 0));
    end
  endtask

  initial begin
    int phase_no;
    logic [7:0] list_words[14];
    list_words = '{8'h00, 8'h00, 8'h00, 8'h00,
                   8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h01, 8'h00, 8'h00, 8'h00, 8'hFF};
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.end_of_buffer <= 1'b0;
    items_sent = 0;
    calm = 1'b0;
    gaps_on = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field count 0 acts as one field. An optional bool with a set tag, then
    // a null tag as a message of its own.
    configure(5'd0, 64'h8, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);

    // An unknown type code gives null whatever the tag. The record ends
    // without end of buffer, so the next word is trailing data and the one
    // after it is dropped.
    hold_until_drained();
    write_reg(brsp_pkg::REG_FIELD_TYPES, 64'hF);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b1);

    // Counted list: first an empty list, then one record of a false bool and
    // a one-byte string.
    hold_until_drained();
    configure(5'd2, 64'h43, 1'b1);
    foreach (list_words[k]) send_byte(list_words[k], k == 3 || k == 13);

    // The type changes from float to bool halfway through a word; the value
    // still completes after eight bytes and comes out as an int.
    hold_until_drained();
    configure(5'd1, 64'h2, 1'b0);
    repeat (4) send_byte(8'hFF, 1'b0);
    hold_until_drained();
    write_reg(brsp_pkg::REG_FIELD_TYPES, 64'h3);
    repeat (3) send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);

    // Random messages in phases of one configuration each. The first
    // phases take the extremes of the registers.
    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      hold_until_drained();
      case (phase_no)
        0: configure(5'd16, random_types(), 1'b1);
        1: configure(5'd31, '1, 1'b0);
        2: configure(5'd0, '0, 1'b1);
        3: configure(5'd1, 64'h4, 1'b0);
        default: begin
          configure(($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                 : 5'($urandom_range(1, 4)),
                    random_types(), 1'($urandom_range(0, 1)));
        end
      endcase
      phase_no++;
      repeat ($urandom_range(3, 8)) begin
        if (items_sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
        if ($urandom_range(0, 9) == 0) begin
          send_noise();
        end else begin
          send_message();
        end
        if ($urandom_range(0, 11) == 0) hold_until_drained();
      end
    end

    calm = 1'b1;
    hold_until_drained();
    if (decoder.mismatches == 0 && decoder.due_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
